// ----- hw/rtl/card_frame_parser_and_matcher_defines.svh -----
// ----------------------------------------------------------------------------
// Card frame parser and matcher: assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CARD_FRAME_PARSER_AND_MATCHER_DEFINES_SVH
`define CARD_FRAME_PARSER_AND_MATCHER_DEFINES_SVH

// Same-cycle implication.
`define CFPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cfpm_pkg.sv -----
// ----------------------------------------------------------------------------
// cfpm_pkg
// Types, codes and header table for the card frame parser and matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpm_pkg;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int ID_W   = 32;
  localparam int EV_W   = 2;
  localparam int RTY_W  = 2;
  localparam int POS_W  = 4;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENROLL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd2;

  // Event codes
  localparam logic [EV_W-1:0] EV_NONE       = 2'd0;
  localparam logic [EV_W-1:0] EV_ENROLLED   = 2'd1;
  localparam logic [EV_W-1:0] EV_AUTHORIZED = 2'd2;
  localparam logic [EV_W-1:0] EV_DENIED     = 2'd3;

  localparam logic [RTY_W-1:0] RETRY_MAX = 2'd3;

  // Frame positions: 0 idle, 1..6 header matched, 7..10 capturing ID
  localparam logic [POS_W-1:0] POS_IDLE = 4'd0;
  localparam logic [POS_W-1:0] HDR_LEN  = 4'd7;
  localparam logic [POS_W-1:0] ID_END   = 4'd10;

  typedef struct packed {
    logic            done;
    logic [ID_W-1:0] id;
  } card_t;

  // Expected header byte at each header position
  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [2:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      3'd0:    b = 8'h04;
      3'd1:    b = 8'h0C;
      3'd2:    b = 8'h02;
      3'd3:    b = 8'h30;
      3'd4:    b = 8'h00;
      3'd5:    b = 8'h04;
      3'd6:    b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cfpm_in_if.sv -----
// ----------------------------------------------------------------------------
// cfpm_in_if
// Request channel: command and received byte with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfpm_in_if;
  logic                         valid;
  logic                         ready;
  logic [cfpm_pkg::CMD_W-1:0]   command;
  logic [cfpm_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cfpm_out_if.sv -----
// ----------------------------------------------------------------------------
// cfpm_out_if
// Result channel: event and session status with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [cfpm_pkg::EV_W-1:0]   event_res;
  logic [cfpm_pkg::ID_W-1:0]   last_card_id;
  logic [cfpm_pkg::RTY_W-1:0]  retries;
  logic                        unlocked;
  logic                        has_card;

  modport source (output valid, event_res, last_card_id, retries, unlocked, has_card,
                  input ready);
  modport sink   (input valid, event_res, last_card_id, retries, unlocked, has_card,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cfpm_parser.sv -----
// ----------------------------------------------------------------------------
// cfpm_parser
// Header match and card ID capture; flags the request that completes an ID.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpm_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [cfpm_pkg::CMD_W-1:0]    command,
  input  wire logic [cfpm_pkg::BYTE_W-1:0]   data_byte,
  output cfpm_pkg::card_t                    card
);

  logic [cfpm_pkg::POS_W-1:0] frame_position, frame_position_next;
  logic [23:0]                partial_id, partial_id_next;

  always_comb begin
    frame_position_next = frame_position;
    partial_id_next     = partial_id;
    case (command)
      cfpm_pkg::CMD_BYTE: begin
        if (frame_position == cfpm_pkg::POS_IDLE) begin
          if (data_byte == cfpm_pkg::hdr_byte(3'd0)) begin
            frame_position_next = 4'd1;
          end
        end else if (frame_position < cfpm_pkg::HDR_LEN) begin
          frame_position_next = (data_byte == cfpm_pkg::hdr_byte(frame_position[2:0]))
                              ? frame_position + 4'd1 : cfpm_pkg::POS_IDLE;
        end else if (frame_position < cfpm_pkg::ID_END) begin
          partial_id_next     = {partial_id[15:0], data_byte};
          frame_position_next = frame_position + 4'd1;
        end else begin
          // ID complete, or a position that cannot occur: back to idle
          frame_position_next = cfpm_pkg::POS_IDLE;
        end
      end
      cfpm_pkg::CMD_ENROLL, cfpm_pkg::CMD_LOCK: begin
        frame_position_next = cfpm_pkg::POS_IDLE;
      end
      default: begin
      end
    endcase
  end

  assign card.done = (command == cfpm_pkg::CMD_BYTE) && (frame_position == cfpm_pkg::ID_END);
  assign card.id   = {partial_id, data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= cfpm_pkg::POS_IDLE;
      partial_id     <= '0;
    end else if (step) begin
      frame_position <= frame_position_next;
      partial_id     <= partial_id_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/card_frame_parser_and_matcher.sv -----
// ----------------------------------------------------------------------------
// card_frame_parser_and_matcher
// Reader frame parser with single-card enrolment and match.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one command per transfer: a received reader byte, start
//   enrolment, or lock. Bytes are scanned for the header 04 0C 02 30 00 04 00
//   followed by a four-byte card ID, first byte in the top bits.
//   result returns exactly one item per request: the event the request caused
//   (none, enrolled, authorised, denied) plus last card ID, retries,
//   unlocked and has_card as they stand after that request.
//   A request passes from one input register through the parser and matcher
//   logic into the result register. Throughput is one request per cycle
//   while result is not stalled; the critical path is the 32-bit card compare
//   feeding the retry and unlock update.
//   When the result is stalled the result register holds, the input register
//   keeps one more request, and request.ready drops only when both are full.
//   Synchronous reset empties both registers, idles the parser and clears
//   the stored card, retries, unlocked and enrolment state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "card_frame_parser_and_matcher_defines.svh"

module card_frame_parser_and_matcher (
  input wire logic   clk,
  input wire logic   rst,
  cfpm_in_if.sink    request,
  cfpm_out_if.source result
);

  // Input register
  logic                         in_valid;
  logic [cfpm_pkg::CMD_W-1:0]   cmd_q;
  logic [cfpm_pkg::BYTE_W-1:0]  byte_q;

  // Session state
  logic [cfpm_pkg::ID_W-1:0]    last_id, last_id_next;
  logic [cfpm_pkg::ID_W-1:0]    enrolled_id, enrolled_id_next;
  logic                         enrolled_valid, enrolled_valid_next;
  logic                         enroll_pending, enroll_pending_next;
  logic [cfpm_pkg::RTY_W-1:0]   fail_count, fail_count_next;
  logic                         unlock_flag, unlock_flag_next;
  logic [cfpm_pkg::EV_W-1:0]    ev_next;

  // Result register
  logic                         out_valid;
  logic [cfpm_pkg::EV_W-1:0]    ev_q;

  logic            advance;
  cfpm_pkg::card_t card;

  // Advance the held request whenever the result register is free or draining
  assign advance       = in_valid && (!out_valid || result.ready);
  assign request.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (request.ready) begin
      in_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      cmd_q  <= request.command;
      byte_q <= request.data_byte;
    end
  end

  cfpm_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .command   (cmd_q),
    .data_byte (byte_q),
    .card      (card)
  );

  // Enrolment, match and retry bookkeeping
  always_comb begin
    last_id_next        = last_id;
    enrolled_id_next    = enrolled_id;
    enrolled_valid_next = enrolled_valid;
    enroll_pending_next = enroll_pending;
    fail_count_next     = fail_count;
    unlock_flag_next    = unlock_flag;
    ev_next             = cfpm_pkg::EV_NONE;
    case (cmd_q)
      cfpm_pkg::CMD_BYTE: begin
        if (card.done) begin
          last_id_next = card.id;
          if (enroll_pending) begin
            enrolled_id_next    = card.id;
            enrolled_valid_next = 1'b1;
            enroll_pending_next = 1'b0;
            fail_count_next     = '0;
            ev_next             = cfpm_pkg::EV_ENROLLED;
          end else if (enrolled_valid && (enrolled_id == card.id)) begin
            unlock_flag_next = 1'b1;
            fail_count_next  = '0;
            ev_next          = cfpm_pkg::EV_AUTHORIZED;
          end else begin
            // Saturate the retry count
            if (fail_count != cfpm_pkg::RETRY_MAX) begin
              fail_count_next = fail_count + 2'd1;
            end
            ev_next = cfpm_pkg::EV_DENIED;
          end
        end
      end
      cfpm_pkg::CMD_ENROLL: begin
        enroll_pending_next = 1'b1;
      end
      cfpm_pkg::CMD_LOCK: begin
        // Keep the stored card; drop the session
        fail_count_next     = '0;
        unlock_flag_next    = 1'b0;
        enroll_pending_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_id        <= '0;
      enrolled_id    <= '0;
      enrolled_valid <= 1'b0;
      enroll_pending <= 1'b0;
      fail_count     <= '0;
      unlock_flag    <= 1'b0;
    end else if (advance) begin
      last_id        <= last_id_next;
      enrolled_id    <= enrolled_id_next;
      enrolled_valid <= enrolled_valid_next;
      enroll_pending <= enroll_pending_next;
      fail_count     <= fail_count_next;
      unlock_flag    <= unlock_flag_next;
    end
  end

  // Result register: load on advance, release when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_q <= ev_next;
    end
  end

  // Status fields mirror the session state, which only moves on advance
  assign result.valid        = out_valid;
  assign result.event_res    = ev_q;
  assign result.last_card_id = last_id;
  assign result.retries      = fail_count;
  assign result.unlocked     = unlock_flag;
  assign result.has_card     = enrolled_valid;

  `CFPM_ASSERT_NOW(a_auth_state,
    out_valid && (ev_q == cfpm_pkg::EV_AUTHORIZED),
    unlock_flag && (fail_count == '0) && enrolled_valid,
    "authorised event without unlocked session")
  `CFPM_ASSERT_NOW(a_enrol_state,
    out_valid && (ev_q == cfpm_pkg::EV_ENROLLED),
    enrolled_valid && !enroll_pending && (fail_count == '0),
    "enrolled event without stored card")
  `CFPM_ASSERT_NEXT(a_retry_step, 1'b1,
    (fail_count == '0) || (fail_count == $past(fail_count))
      || (fail_count == $past(fail_count) + 2'd1),
    "retry count moved by more than one")
  `CFPM_ASSERT_NEXT(a_hold_pending, in_valid && out_valid && !result.ready,
    in_valid && out_valid && $stable(ev_q) && $stable(fail_count),
    "stalled result or pending request lost")

endmodule

`default_nettype wire
